### rtl/core/olc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olc_pkg;

	localparam logic [15:0] RESET_HOLD_TICKS = 16'd200;
	localparam logic [7:0] RESET_REBROADCAST_MASK = 8'd1;
	localparam logic [7:0] RESET_MIN_LEVEL = 8'd10;
	localparam logic [7:0] RESET_MAX_LEVEL = 8'd100;
	localparam logic [7:0] NEIGHBOUR_NUM = 8'd8;

	// Reciprocal of ten for an 8-bit dividend: (x * 205) >> 11 is exact up to 255.
	localparam logic [7:0] RECIP_TEN = 8'd205;
	localparam int RECIP_SHIFT = 11;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HOLD_TICKS       = 2'd0,
		CFG_REBROADCAST_MASK = 2'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_SLEEPING      = 3'd0,
		ST_AWAKE         = 3'd1,
		ST_TRIGGERED     = 3'd2,
		ST_POST          = 3'd3,
		ST_REQ_NEIGHBOUR = 3'd4,
		ST_SET_LEVELS    = 3'd5,
		ST_SET_OPERATION = 3'd6,
		ST_UNKNOWN       = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		PEND_NONE      = 2'd0,
		PEND_NEIGHBOUR = 2'd1,
		PEND_LEVELS    = 2'd2,
		PEND_OPERATION = 2'd3
	} pend_t;

	typedef enum logic {
		OP_MESSAGE = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef struct packed {
		logic       operation;
		logic       local_trigger;
		logic [2:0] msg_code;
		logic [7:0] msg_min_level;
		logic [7:0] msg_max_level;
		logic [7:0] msg_flags;
	} item_t;

	typedef struct packed {
		logic [7:0] lamp_level;
		logic       indicator_on;
		logic [2:0] broadcast_state;
		logic [7:0] broadcast_min;
		logic [7:0] broadcast_max;
	} result_t;

	typedef struct packed {
		logic [15:0] hold_ticks;
		logic [7:0]  rebroadcast_mask;
	} cfg_t;

	typedef struct packed {
		status_t     own_state;
		logic [15:0] hold_timer;
		logic        neighbour_hold;
		logic [7:0]  min_level;
		logic [7:0]  max_level;
		pend_t       pending_request;
		logic [7:0]  pending_flags;
		logic [7:0]  last_msg_min;
		logic [7:0]  last_msg_max;
	} ctrl_state_t;

endpackage

`default_nettype wire

### rtl/core/olc_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface olc_item_if;
	logic            valid;
	logic            ready;
	olc_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/olc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface olc_result_if;
	logic              valid;
	logic              ready;
	olc_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/occupancy_light_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Occupancy controller for one street lamp.
// The item channel carries two kinds of request: neighbour messages and
// control ticks. A message is recorded until the next tick and produces no
// result. A tick applies the recorded request, then the local sensor trigger
// or the hold-timer countdown, and produces exactly one result request on
// the result channel: lamp level, indicator and the status to broadcast.
// The controller state is updated at the edge that accepts the item, and a
// tick's result appears in the output register on the next cycle; one item
// can be accepted in every cycle unless the result channel stalls. The
// output register is the only buffer: while a result waits and the
// receiver holds ready low, item ready drops; messages and ticks alike
// then wait until the result is taken.
// The configuration port writes hold_ticks (index 0) and rebroadcast_mask
// (index 1); writes are meant to happen only while no tick result is pending.
// Reset returns the lamp to sleeping with levels 10 and 100, no pending
// request, hold time 200 ticks and a rebroadcast mask of one.

module occupancy_light_controller_core (
	input  wire                              clk,
	input  wire                              arst_n,
	olc_item_if.sink                         item,
	olc_result_if.source                     result,
	input  wire                              cfg_we,
	input  wire [olc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire [olc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	olc_pkg::ctrl_state_t state_q;
	olc_pkg::ctrl_state_t state_next;
	olc_pkg::cfg_t        cfg_q;
	olc_pkg::result_t     res_next;
	olc_pkg::result_t     res_q;
	logic                 res_valid_q;
	logic                 accept;

	assign item.ready  = !res_valid_q || result.ready;
	assign accept      = item.valid && item.ready;
	assign result.valid = res_valid_q;
	assign result.data = res_q;

	olc_update u_update (
		.cur  (state_q),
		.item (item.data),
		.cfg  (cfg_q),
		.nxt  (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks       <= olc_pkg::RESET_HOLD_TICKS;
			cfg_q.rebroadcast_mask <= olc_pkg::RESET_REBROADCAST_MASK;
		end else if (cfg_we) begin
			unique case (olc_pkg::cfg_index_t'(cfg_index))
				olc_pkg::CFG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data;
				olc_pkg::CFG_REBROADCAST_MASK: cfg_q.rebroadcast_mask <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.own_state       <= olc_pkg::ST_SLEEPING;
			state_q.hold_timer      <= 16'd0;
			state_q.neighbour_hold  <= 1'b0;
			state_q.min_level       <= olc_pkg::RESET_MIN_LEVEL;
			state_q.max_level       <= olc_pkg::RESET_MAX_LEVEL;
			state_q.pending_request <= olc_pkg::PEND_NONE;
			state_q.pending_flags   <= 8'd0;
			state_q.last_msg_min    <= 8'd0;
			state_q.last_msg_max    <= 8'd0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && item.data.operation == olc_pkg::OP_TICK) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.data.operation == olc_pkg::OP_TICK) begin
			res_q <= res_next;
		end
	end

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.data.operation == olc_pkg::OP_TICK |=> result.valid)
		else $error("tick accepted without a result");

	a_tick_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.data.operation == olc_pkg::OP_TICK
		|=> state_q.pending_request == olc_pkg::PEND_NONE && state_q.pending_flags == 8'd0)
		else $error("pending request survived a tick");

	a_message_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.data.operation == olc_pkg::OP_MESSAGE && !result.valid
		|=> !result.valid)
		else $error("message produced a result");

endmodule

`default_nettype wire

### rtl/core/olc_update.sv
`timescale 1ns / 1ps
`default_nettype none

module olc_update (
	input  olc_pkg::ctrl_state_t cur,
	input  olc_pkg::item_t       item,
	input  olc_pkg::cfg_t        cfg,
	output olc_pkg::ctrl_state_t nxt,
	output olc_pkg::result_t     res
);

	logic [7:0]  level_max;
	logic [18:0] scaled_max;
	logic [7:0]  tenth_max;
	logic [7:0]  reduced_level;
	logic [7:0]  level;
	logic [15:0] timer_dec;

	// The maximum level that holds after a pending set-levels request, and a tenth of it times NEIGHBOUR_NUM.
	always_comb begin
		level_max     = (cur.pending_request == olc_pkg::PEND_LEVELS) ? cur.last_msg_max
		                                                              : cur.max_level;
		scaled_max    = 19'(level_max) * 19'(olc_pkg::RECIP_TEN);
		tenth_max     = 8'(scaled_max >> olc_pkg::RECIP_SHIFT);
		reduced_level = 8'(tenth_max * olc_pkg::NEIGHBOUR_NUM);
	end

	always_comb begin
		nxt       = cur;
		level     = cur.min_level;
		timer_dec = 16'd0;
		if (item.operation == olc_pkg::OP_MESSAGE) begin
			nxt.last_msg_min = item.msg_min_level;
			nxt.last_msg_max = item.msg_max_level;
			unique case (olc_pkg::status_t'(item.msg_code))
				olc_pkg::ST_REQ_NEIGHBOUR: begin
					nxt.pending_request = olc_pkg::PEND_NEIGHBOUR;
				end
				olc_pkg::ST_SET_LEVELS: begin
					nxt.pending_request = olc_pkg::PEND_LEVELS;
					nxt.pending_flags   = item.msg_flags;
				end
				olc_pkg::ST_SET_OPERATION: begin
					nxt.pending_request = olc_pkg::PEND_OPERATION;
					nxt.pending_flags   = item.msg_flags;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (cur.pending_request)
				olc_pkg::PEND_OPERATION: begin
					if (cur.last_msg_min == cur.last_msg_max) begin
						level = cur.last_msg_min;
						if ((cur.pending_flags & cfg.rebroadcast_mask) == cfg.rebroadcast_mask)
							nxt.own_state = olc_pkg::ST_SET_OPERATION;
						else
							nxt.own_state = olc_pkg::ST_AWAKE;
					end
				end
				olc_pkg::PEND_NEIGHBOUR: begin
					if (cur.own_state == olc_pkg::ST_SLEEPING || cur.own_state == olc_pkg::ST_AWAKE
							|| cur.own_state == olc_pkg::ST_POST
							|| cur.own_state == olc_pkg::ST_REQ_NEIGHBOUR) begin
						nxt.hold_timer     = cfg.hold_ticks;
						nxt.neighbour_hold = 1'b1;
					end
				end
				olc_pkg::PEND_LEVELS: begin
					nxt.min_level = cur.last_msg_min;
					nxt.max_level = cur.last_msg_max;
				end
				olc_pkg::PEND_NONE: begin
				end
			endcase

			if (item.local_trigger) begin
				level              = nxt.max_level;
				nxt.own_state      = olc_pkg::ST_REQ_NEIGHBOUR;
				nxt.hold_timer     = cfg.hold_ticks;
				nxt.neighbour_hold = 1'b0;
			end else if (nxt.hold_timer != 16'd0) begin
				timer_dec      = nxt.hold_timer - 16'd1;
				level          = nxt.neighbour_hold ? reduced_level : nxt.max_level;
				nxt.hold_timer = timer_dec;
				nxt.own_state  = olc_pkg::ST_POST;
				if (timer_dec == 16'd0) begin
					level         = nxt.min_level;
					nxt.own_state = olc_pkg::ST_AWAKE;
				end
			end

			nxt.pending_request = olc_pkg::PEND_NONE;
			nxt.pending_flags   = 8'd0;
			nxt.last_msg_min    = 8'd0;
			nxt.last_msg_max    = 8'd0;
		end

		res.lamp_level      = level;
		res.indicator_on    = (level > nxt.min_level);
		res.broadcast_state = nxt.own_state;
		res.broadcast_min   = nxt.min_level;
		res.broadcast_max   = nxt.max_level;
	end

endmodule

`default_nettype wire

### tb/occupancy_light_controller_core_tb.sv
`timescale 1ns / 1ps

module occupancy_light_controller_core_tb;

	localparam int ITEM_W = $bits(olc_pkg::item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [olc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [olc_pkg::CFG_DATA_W-1:0] cfg_data;

	olc_item_if item_ch();
	olc_result_if result_ch();

	occupancy_light_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	olc_pkg::item_t pending_items[$];
	olc_pkg::result_t awaited_results[$];

	int tx_gap_max = 11;
	int rx_gap_max = 11;
	int tx_wait;
	int rx_stall;
	int rx_draw;
	int mismatches = 0;
	logic rx_hold = 1'b0;
	logic long_hold_go = 1'b0;

	// Predicted controller state and register copies.
	logic [15:0] hold_cfg = olc_pkg::RESET_HOLD_TICKS;
	logic [7:0] mask_cfg = olc_pkg::RESET_REBROADCAST_MASK;
	olc_pkg::status_t lamp_state = olc_pkg::ST_SLEEPING;
	logic [15:0] timer_left = 16'd0;
	logic neighbour_mode = 1'b0;
	logic [7:0] min_lvl = olc_pkg::RESET_MIN_LEVEL;
	logic [7:0] max_lvl = olc_pkg::RESET_MAX_LEVEL;
	olc_pkg::pend_t pend_req = olc_pkg::PEND_NONE;
	logic [7:0] pend_flags = 8'd0;
	logic [7:0] seen_min = 8'd0;
	logic [7:0] seen_max = 8'd0;

	function automatic void predict_controller(input olc_pkg::item_t it);
		logic [7:0] level;
		olc_pkg::status_t nxt;
		olc_pkg::result_t r;
		if (it.operation == olc_pkg::OP_MESSAGE) begin
			seen_min = it.msg_min_level;
			seen_max = it.msg_max_level;
			if (it.msg_code == olc_pkg::ST_REQ_NEIGHBOUR) begin
				pend_req = olc_pkg::PEND_NEIGHBOUR;
			end else if (it.msg_code == olc_pkg::ST_SET_LEVELS) begin
				pend_req = olc_pkg::PEND_LEVELS;
				pend_flags = it.msg_flags;
			end else if (it.msg_code == olc_pkg::ST_SET_OPERATION) begin
				pend_req = olc_pkg::PEND_OPERATION;
				pend_flags = it.msg_flags;
			end
		end else begin
			level = min_lvl;
			nxt = lamp_state;
			case (pend_req)
				olc_pkg::PEND_OPERATION: begin
					if (seen_min == seen_max) begin
						level = seen_min;
						nxt = ((pend_flags & mask_cfg) == mask_cfg) ? olc_pkg::ST_SET_OPERATION
						                                            : olc_pkg::ST_AWAKE;
					end
				end
				olc_pkg::PEND_NEIGHBOUR: begin
					if (lamp_state == olc_pkg::ST_SLEEPING || lamp_state == olc_pkg::ST_AWAKE ||
					    lamp_state == olc_pkg::ST_REQ_NEIGHBOUR ||
					    lamp_state == olc_pkg::ST_POST) begin
						timer_left = hold_cfg;
						neighbour_mode = 1'b1;
					end
				end
				olc_pkg::PEND_LEVELS: begin
					min_lvl = seen_min;
					max_lvl = seen_max;
				end
				default: ;
			endcase
			if (it.local_trigger) begin
				level = max_lvl;
				nxt = olc_pkg::ST_REQ_NEIGHBOUR;
				timer_left = hold_cfg;
				neighbour_mode = 1'b0;
			end else if (timer_left != 16'd0) begin
				level = neighbour_mode ? (max_lvl / 8'd10) * olc_pkg::NEIGHBOUR_NUM : max_lvl;
				timer_left = timer_left - 16'd1;
				nxt = olc_pkg::ST_POST;
				if (timer_left == 16'd0) begin
					level = min_lvl;
					nxt = olc_pkg::ST_AWAKE;
				end
			end
			r.lamp_level = level;
			r.indicator_on = (level > min_lvl);
			r.broadcast_state = nxt;
			r.broadcast_min = min_lvl;
			r.broadcast_max = max_lvl;
			awaited_results.push_back(r);
			lamp_state = nxt;
			pend_req = olc_pkg::PEND_NONE;
			pend_flags = 8'd0;
			seen_min = 8'd0;
			seen_max = 8'd0;
		end
	endfunction

	function automatic olc_pkg::item_t msg_item(input logic [2:0] code, input logic [7:0] mn,
	                                            input logic [7:0] mx, input logic [7:0] fl);
		olc_pkg::item_t it;
		it.operation = olc_pkg::OP_MESSAGE;
		it.local_trigger = 1'($urandom_range(0, 1));
		it.msg_code = code;
		it.msg_min_level = mn;
		it.msg_max_level = mx;
		it.msg_flags = fl;
		return it;
	endfunction

	function automatic olc_pkg::item_t tick_item(input logic trig);
		olc_pkg::item_t it;
		it = olc_pkg::item_t'(ITEM_W'($urandom));
		it.operation = olc_pkg::OP_TICK;
		it.local_trigger = trig;
		return it;
	endfunction

	// Sender side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			tx_wait <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				predict_controller(item_ch.data);
			if (!item_ch.valid || item_ch.ready) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
					item_ch.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_ch.data <= pending_items.pop_front();
					item_ch.valid <= 1'b1;
					tx_wait <= $urandom_range(0, tx_gap_max);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver side and result check.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result request with nothing awaited: %h", $realtime,
						         result_ch.data);
				end else begin
					olc_pkg::result_t want;
					want = awaited_results.pop_front();
					if (result_ch.data.lamp_level !== want.lamp_level ||
					    result_ch.data.indicator_on !== want.indicator_on ||
					    result_ch.data.broadcast_state !== want.broadcast_state ||
					    result_ch.data.broadcast_min !== want.broadcast_min ||
					    result_ch.data.broadcast_max !== want.broadcast_max) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected lamp %0d ind %0d state %0d min %0d max %0d",
							         $realtime, want.lamp_level, want.indicator_on,
							         want.broadcast_state, want.broadcast_min,
							         want.broadcast_max, "\n    got lamp %0d ind %0d state %0d",
							         result_ch.data.lamp_level, result_ch.data.indicator_on,
							         result_ch.data.broadcast_state, " min %0d max %0d",
							         result_ch.data.broadcast_min, result_ch.data.broadcast_max);
					end
				end
				rx_draw = $urandom_range(0, rx_gap_max);
				rx_stall <= rx_draw;
				result_ch.ready <= (rx_draw == 0) && !rx_hold;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !rx_hold;
			end
		end
	end

	// Long receiver hold-off so that the output register fills and item ready drops.
	initial begin
		wait (long_hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#400000;
		$display("[occupancy_light_controller_core] ERROR");
		$finish;
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || awaited_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input olc_pkg::cfg_index_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == olc_pkg::CFG_HOLD_TICKS)
			hold_cfg = val;
		else
			mask_cfg = val[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_random(input int count);
		int n;
		int burst;
		int pick;
		logic [2:0] code;
		logic [7:0] mn;
		logic [7:0] mx;
		logic [7:0] fl;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(0, 3);
			repeat (burst) begin
				pick = $urandom_range(0, 9);
				if (pick < 2)
					code = 3'($urandom_range(0, 7));
				else if (pick < 5)
					code = olc_pkg::ST_REQ_NEIGHBOUR;
				else if (pick < 7)
					code = olc_pkg::ST_SET_LEVELS;
				else
					code = olc_pkg::ST_SET_OPERATION;
				mn = 8'($urandom_range(0, 255));
				mx = 8'($urandom_range(0, 255));
				if (code == olc_pkg::ST_SET_OPERATION && $urandom_range(0, 1))
					mx = mn;
				fl = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1))
					fl = fl | mask_cfg;
				pending_items.push_back(msg_item(code, mn, mx, fl));
				n++;
			end
			pending_items.push_back(tick_item($urandom_range(0, 5) == 0));
			n++;
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SET_OPERATION, 8'd255, 8'd255, 8'hFF));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_REQ_NEIGHBOUR, 8'd0, 8'd0, 8'h00));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SET_LEVELS, 8'd0, 8'd255, 8'h00));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_REQ_NEIGHBOUR, 8'd9, 8'd9, 8'h01));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(tick_item(1'b1));
		pending_items.push_back(msg_item(olc_pkg::ST_REQ_NEIGHBOUR, 8'd255, 8'd0, 8'hFF));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SET_OPERATION, 8'd40, 8'd41, 8'hFF));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SET_OPERATION, 8'd0, 8'd0, 8'h00));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_UNKNOWN, 8'd12, 8'd12, 8'hFF));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SET_LEVELS, 8'd255, 8'd0, 8'hAA));
		pending_items.push_back(msg_item(olc_pkg::ST_REQ_NEIGHBOUR, 8'd1, 8'd2, 8'h03));
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(msg_item(olc_pkg::ST_SLEEPING, 8'd255, 8'd255, 8'hFF));
		pending_items.push_back(msg_item(olc_pkg::ST_AWAKE, 8'd1, 8'd1, 8'h00));
		pending_items.push_back(msg_item(olc_pkg::ST_TRIGGERED, 8'd0, 8'd255, 8'h55));
		pending_items.push_back(tick_item(1'b1));
		wait_idle();

		write_reg(olc_pkg::CFG_HOLD_TICKS, 16'd3);
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'd1);
		long_hold_go = 1'b1;
		add_random(130);
		wait_idle();

		tx_gap_max = 0;
		rx_gap_max = 0;
		write_reg(olc_pkg::CFG_HOLD_TICKS, 16'd1);
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'h00FF);
		add_random(130);
		wait_idle();

		tx_gap_max = 11;
		rx_gap_max = 11;
		write_reg(olc_pkg::CFG_HOLD_TICKS, 16'd0);
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'd0);
		add_random(130);
		wait_idle();

		write_reg(olc_pkg::CFG_HOLD_TICKS, 16'hFFFF);
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'h00A5);
		add_random(100);
		wait_idle();

		write_reg(olc_pkg::CFG_HOLD_TICKS, 16'($urandom_range(1, 20)));
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'($urandom_range(0, 255)));
		add_random(150);
		wait_idle();

		tx_gap_max = 0;
		write_reg(olc_pkg::CFG_HOLD_TICKS, olc_pkg::RESET_HOLD_TICKS);
		write_reg(olc_pkg::CFG_REBROADCAST_MASK, 16'h0080);
		add_random(150);
		wait_idle();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[occupancy_light_controller_core] OK");
		else
			$display("[occupancy_light_controller_core] ERROR");
		$finish;
	end

endmodule
